[hdl/fdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fdf_pkg;

  localparam int SEEN_DEPTH = 256;
  localparam int IDX_W      = $clog2(SEEN_DEPTH);
  localparam int CNT_W      = $clog2(SEEN_DEPTH + 1);
  localparam int GRP_SIZE   = 16;
  localparam int GRP_CNT    = (SEEN_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 16;
  localparam int HOP_W  = 8;
  localparam int KIND_W = 4;
  localparam int PORT_W = 8;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(300);

  localparam logic [1:0] CMD_MESSAGE = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_CLEANUP = 2'd2;

  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_EXPIRED   = 2'd2;
  localparam logic [1:0] ST_DELIVERED = 2'd3;

  // Global, announce and discover are the kinds that get re-flooded.
  localparam logic [KIND_W-1:0] KIND_FLOOD_MAX = KIND_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_GROUP,
    S_ACT,
    S_SWEEP,
    S_EMIT
  } fdf_state_t;

  // Signals broadcast from the controller to every cell.
  typedef struct packed {
    logic              shift;
    logic [ID_W-1:0]   key;
    logic [TIME_W-1:0] now;
    logic [TMO_W-1:0]  timeout;
  } fdf_bcast_t;

endpackage
`default_nettype wire

[hdl/flood_duplicate_filter.sv]
// A beat passes S_EVAL (cells compare), S_GROUP (group OR), S_ACT (result registered)
// and S_EMIT (output loaded); a cleanup sweeps in S_SWEEP between S_ACT and S_EMIT.
// An item is taken only after the last one is loaded out; S_EMIT waits on out_stall.
// Entries drop one per cycle from the oldest end of the row.
// The row of cells shifts once per inserted message; lookups compare in all cells at once.
// Reset (synchronous): store empty, seconds counter 0, timeout 300, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module flood_duplicate_filter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [fdf_pkg::TMO_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [fdf_pkg::ID_W-1:0]   message_id,
  input  wire logic [fdf_pkg::HOP_W-1:0]  hop_limit,
  input  wire logic [fdf_pkg::KIND_W-1:0] message_kind,
  input  wire logic [fdf_pkg::PORT_W-1:0] source_port,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [1:0]                 status,
  output logic                            forward,
  output logic      [fdf_pkg::HOP_W-1:0]  forward_hops,
  output logic      [fdf_pkg::PORT_W-1:0] exclude_port,
  output logic      [fdf_pkg::ID_W-1:0]   echoed_id
);
  import fdf_pkg::*;

  fdf_state_t state, state_next;

  logic [1:0]        cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [HOP_W-1:0]  hops_q;
  logic [KIND_W-1:0] kind_q;
  logic [PORT_W-1:0] port_q;

  logic [CNT_W-1:0]  entry_count, count_next;
  logic [TIME_W-1:0] now_seconds, now_next;
  logic [TMO_W-1:0]  timeout_seconds;

  logic [1:0]        res_status, res_status_next;
  logic              res_fwd, res_fwd_next;
  logic [HOP_W-1:0]  res_hops, res_hops_next;
  logic [PORT_W-1:0] res_excl, res_excl_next;
  logic [ID_W-1:0]   res_id, res_id_next;

  logic              shift_en, res_load, out_load, dup;
  logic [IDX_W-1:0]  sweep_idx;
  fdf_bcast_t        bc;

  logic [ID_W-1:0]   cell_id    [SEEN_DEPTH];
  logic [TIME_W-1:0] cell_stamp [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] hit_vec, aged_vec, live_vec;
  logic [GRP_CNT*GRP_SIZE-1:0] hit_pad;
  logic [GRP_CNT-1:0] grp_or, grp_q;

  assign bc.shift   = shift_en;
  assign bc.key     = id_q;
  assign bc.now     = now_seconds;
  assign bc.timeout = timeout_seconds;

  // Cell 0 holds the newest entry; an insert pushes every entry one cell along
  // and the entry in the last cell falls off when the row is full.
  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]   prev_id;
    logic [TIME_W-1:0] prev_stamp;

    if (i == 0) begin : g_head
      assign prev_id    = id_q;
      assign prev_stamp = now_seconds;
    end else begin : g_link
      assign prev_id    = cell_id[i-1];
      assign prev_stamp = cell_stamp[i-1];
    end

    assign live_vec[i] = entry_count > CNT_W'(i);

    fdf_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .live       (live_vec[i]),
      .prev_id    (prev_id),
      .prev_stamp (prev_stamp),
      .id         (cell_id[i]),
      .stamp      (cell_stamp[i]),
      .hit        (hit_vec[i]),
      .aged       (aged_vec[i])
    );
  end

  assign hit_pad = (GRP_CNT*GRP_SIZE)'(hit_vec);

  for (genvar g = 0; g < GRP_CNT; g++) begin : g_grp
    assign grp_or[g] = |hit_pad[g*GRP_SIZE +: GRP_SIZE];
  end

  always_ff @(posedge clk) begin
    grp_q <= grp_or;
  end

  assign dup       = |grp_q;
  assign sweep_idx = IDX_W'(entry_count - CNT_W'(1));
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    res_status_next = ST_NONE;
    res_fwd_next    = 1'b0;
    res_hops_next   = '0;
    res_excl_next   = '0;
    res_id_next     = '0;
    if (cmd_q == CMD_MESSAGE) begin
      res_id_next = id_q;
      if (dup) begin
        res_status_next = ST_DUPLICATE;
      end else if (hops_q == '0) begin
        res_status_next = ST_EXPIRED;
      end else begin
        res_status_next = ST_DELIVERED;
        if (kind_q <= KIND_FLOOD_MAX && hops_q > HOP_W'(1)) begin
          res_fwd_next  = 1'b1;
          res_hops_next = hops_q - HOP_W'(1);
          res_excl_next = port_q;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    shift_en   = 1'b0;
    count_next = entry_count;
    now_next   = now_seconds;
    res_load   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL:  state_next = S_GROUP;
      S_GROUP: state_next = S_ACT;
      S_ACT: begin
        res_load   = 1'b1;
        state_next = S_EMIT;
        case (cmd_q)
          CMD_MESSAGE: begin
            if (!dup) begin
              shift_en = 1'b1;
              if (entry_count < CNT_W'(SEEN_DEPTH)) count_next = entry_count + CNT_W'(1);
            end
          end
          CMD_TICK: now_next = now_seconds + TIME_W'(1);
          CMD_CLEANUP: state_next = S_SWEEP;
          default: ;
        endcase
      end
      S_SWEEP: begin
        // Drop from the oldest end while the oldest live entry has aged out.
        if (entry_count != '0 && aged_vec[sweep_idx]) begin
          count_next = entry_count - CNT_W'(1);
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_count     <= '0;
      now_seconds     <= '0;
      timeout_seconds <= TIMEOUT_RESET;
      out_valid       <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      now_seconds <= now_next;
      if (cfg_write) timeout_seconds <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q  <= command;
      id_q   <= message_id;
      hops_q <= hop_limit;
      kind_q <= message_kind;
      port_q <= source_port;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_fwd    <= res_fwd_next;
      res_hops   <= res_hops_next;
      res_excl   <= res_excl_next;
      res_id     <= res_id_next;
    end
    if (out_load) begin
      status       <= res_status;
      forward      <= res_fwd;
      forward_hops <= res_hops;
      exclude_port <= res_excl;
      echoed_id    <= res_id;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(SEEN_DEPTH))
    else $error("entry count beyond store depth");

  a_sweep_shrinks: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |=> entry_count <= $past(entry_count))
    else $error("entry count grew during cleanup");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT && cmd_q == CMD_TICK) |=> now_seconds == $past(now_seconds) + TIME_W'(1))
    else $error("tick did not advance the seconds counter");

  a_fwd_delivered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && forward) |-> status == ST_DELIVERED)
    else $error("forward set on a message that was not delivered");

endmodule
`default_nettype wire

[hdl/fdf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module fdf_cell (
  input  wire logic                       clk,
  input  wire fdf_pkg::fdf_bcast_t        bc,
  input  wire logic                       live,
  input  wire logic [fdf_pkg::ID_W-1:0]   prev_id,
  input  wire logic [fdf_pkg::TIME_W-1:0] prev_stamp,
  output logic      [fdf_pkg::ID_W-1:0]   id,
  output logic      [fdf_pkg::TIME_W-1:0] stamp,
  output logic                            hit,
  output logic                            aged
);
  import fdf_pkg::*;

  logic [TIME_W-1:0] age;

  assign age = bc.now - stamp;

  always_ff @(posedge clk) begin
    if (bc.shift) begin
      id    <= prev_id;
      stamp <= prev_stamp;
    end
    hit  <= live && (id == bc.key);
    aged <= live && (age > TIME_W'(bc.timeout));
  end

endmodule
`default_nettype wire

[sim/fdf_checker.sv]
`timescale 1ns / 1ps
module fdf_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [fdf_pkg::TMO_W-1:0]  cfg_data,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [1:0]                 command,
  input  wire logic [fdf_pkg::ID_W-1:0]   message_id,
  input  wire logic [fdf_pkg::HOP_W-1:0]  hop_limit,
  input  wire logic [fdf_pkg::KIND_W-1:0] message_kind,
  input  wire logic [fdf_pkg::PORT_W-1:0] source_port,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [1:0]                 status,
  input  wire logic                       forward,
  input  wire logic [fdf_pkg::HOP_W-1:0]  forward_hops,
  input  wire logic [fdf_pkg::PORT_W-1:0] exclude_port,
  input  wire logic [fdf_pkg::ID_W-1:0]   echoed_id,
  output int                              mismatches,
  output int                              outstanding
);
  import fdf_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic              forward;
    logic [HOP_W-1:0]  hops;
    logic [PORT_W-1:0] excl;
    logic [ID_W-1:0]   id;
  } verdict_t;

  // Own copy of the seen ring, the clock and the timeout.
  logic [ID_W-1:0]   id_ring   [SEEN_DEPTH];
  logic [TIME_W-1:0] time_ring [SEEN_DEPTH];
  int                ring_head;
  int                ring_fill;
  logic [TIME_W-1:0] sec_count;
  logic [TMO_W-1:0]  timeout_now;
  verdict_t          awaiting [$];
  int                fail_tally = 0;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fail_tally++;
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic filter_message(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [HOP_W-1:0] hops,
                                input logic [KIND_W-1:0] kind,
                                input logic [PORT_W-1:0] port, output verdict_t v);
    int   slot;
    logic hit;
    v   = '0;
    hit = 1'b0;
    case (cmd)
      CMD_MESSAGE: begin
        v.id = id;
        for (int i = 0; i < ring_fill; i++)
          if (id_ring[(ring_head + i) % SEEN_DEPTH] == id)
            hit = 1'b1;
        if (hit) begin
          v.status = ST_DUPLICATE;
        end else begin
          // A full ring loses its oldest entry to the new one.
          if (ring_fill < SEEN_DEPTH) begin
            slot = (ring_head + ring_fill) % SEEN_DEPTH;
            ring_fill++;
          end else begin
            slot      = ring_head;
            ring_head = (ring_head + 1) % SEEN_DEPTH;
          end
          id_ring[slot]   = id;
          time_ring[slot] = sec_count;
          if (hops == '0) begin
            v.status = ST_EXPIRED;
          end else begin
            v.status = ST_DELIVERED;
            if (kind <= KIND_FLOOD_MAX && hops > HOP_W'(1)) begin
              v.forward = 1'b1;
              v.hops    = hops - HOP_W'(1);
              v.excl    = port;
            end
          end
        end
      end
      CMD_TICK: begin
        sec_count = sec_count + TIME_W'(1);
      end
      CMD_CLEANUP: begin
        // Ages are taken modulo 2^32, so a wrapped counter still ages correctly.
        while (ring_fill > 0 &&
               (sec_count - time_ring[ring_head]) > TIME_W'(timeout_now)) begin
          ring_head = (ring_head + 1) % SEEN_DEPTH;
          ring_fill--;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t fresh;
    if (rst) begin
      ring_head   = 0;
      ring_fill   = 0;
      sec_count   = '0;
      timeout_now = TIMEOUT_RESET;
      awaiting.delete();
    end else begin
      if (cfg_write)
        timeout_now = cfg_data;
      if (out_valid && !out_stall) begin
        if (awaiting.size() == 0) begin
          note_mismatch("result beat with nothing outstanding, echoed_id", echoed_id, '0);
        end else begin
          want = awaiting.pop_front();
          if (status !== want.status)
            note_mismatch("status", status, want.status);
          if (forward !== want.forward)
            note_mismatch("forward", forward, want.forward);
          if (forward_hops !== want.hops)
            note_mismatch("forward_hops", forward_hops, want.hops);
          if (exclude_port !== want.excl)
            note_mismatch("exclude_port", exclude_port, want.excl);
          if (echoed_id !== want.id)
            note_mismatch("echoed_id", echoed_id, want.id);
        end
      end
      if (in_valid && !in_stall) begin
        filter_message(command, message_id, hop_limit, message_kind, source_port, fresh);
        awaiting = {awaiting, fresh};
      end
    end
    mismatches  <= fail_tally;
    outstanding <= awaiting.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
  import fdf_pkg::*;

  // The block accepts command 3 and ignores it.
  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         QUIET_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         PHASE_ITEMS   = 235;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_RUNS
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [TMO_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = CMD_MESSAGE;
  logic [ID_W-1:0]   message_id = '0;
  logic [HOP_W-1:0]  hop_limit = '0;
  logic [KIND_W-1:0] message_kind = '0;
  logic [PORT_W-1:0] source_port = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic              forward;
  logic [HOP_W-1:0]  forward_hops;
  logic [PORT_W-1:0] exclude_port;
  logic [ID_W-1:0]   echoed_id;

  int                mismatches;
  int                outstanding;
  int                quiet_cycles = 0;
  int                burst_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;
  int                mode_left = 0;
  int                hold_left = 0;
  logic [ID_W-1:0]   id_pool [$];

  always #5 clk = ~clk;

  flood_duplicate_filter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .message_id   (message_id),
    .hop_limit    (hop_limit),
    .message_kind (message_kind),
    .source_port  (source_port),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .forward      (forward),
    .forward_hops (forward_hops),
    .exclude_port (exclude_port),
    .echoed_id    (echoed_id)
  );

  fdf_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .message_id   (message_id),
    .hop_limit    (hop_limit),
    .message_kind (message_kind),
    .source_port  (source_port),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .forward      (forward),
    .forward_hops (forward_hops),
    .exclude_port (exclude_port),
    .echoed_id    (echoed_id),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // The receiver switches between four stall patterns, each held for a random stretch.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall = 1'b0;
      end
      STALL_LIGHT: begin
        out_stall = ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        out_stall = ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 30);
          out_stall = ~out_stall;
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                           input logic [HOP_W-1:0] hops, input logic [KIND_W-1:0] kind,
                           input logic [PORT_W-1:0] port);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    command      = cmd;
    message_id   = id;
    hop_limit    = hops;
    message_kind = kind;
    source_port  = port;
    in_valid     = 1'b1;
    if (cmd == CMD_MESSAGE) begin
      id_pool = {id_pool, id};
      if (id_pool.size() > 64)
        id_pool.delete(0);
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_timeout(input logic [TMO_W-1:0] value);
    wait_drained();
    cfg_data  = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && id_pool.size() > 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    else if (r < 55)
      return ID_W'($urandom_range(0, 63));
    else
      return $urandom;
  endfunction

  function automatic logic [HOP_W-1:0] pick_hops();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return '0;
    else if (r < 30)
      return HOP_W'(1);
    else if (r < 40)
      return HOP_W'(2);
    else if (r < 48)
      return '1;
    else
      return HOP_W'($urandom_range(0, 255));
  endfunction

  task automatic random_beat();
    int r;
    logic [KIND_W-1:0] kind;
    if ($urandom_range(0, 49) == 0)
      wait_drained();
    kind = ($urandom_range(0, 1) == 0) ? KIND_W'($urandom_range(0, 2))
                                       : KIND_W'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 70)
      send_beat(CMD_MESSAGE, pick_id(), pick_hops(), kind, PORT_W'($urandom_range(0, 255)));
    else if (r < 85)
      send_beat(CMD_TICK, $urandom, pick_hops(), kind, PORT_W'($urandom_range(0, 255)));
    else if (r < 95)
      send_beat(CMD_CLEANUP, $urandom, pick_hops(), kind, PORT_W'($urandom_range(0, 255)));
    else
      send_beat(CMD_UNUSED, $urandom, pick_hops(), kind, PORT_W'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [TMO_W-1:0] timeouts [6];
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed beats under the reset timeout.
    send_beat(CMD_MESSAGE, '0, '0, KIND_W'(0), '0);
    send_beat(CMD_MESSAGE, '0, HOP_W'(5), KIND_W'(0), PORT_W'(3));
    send_beat(CMD_MESSAGE, '1, '1, KIND_W'(0), '1);
    send_beat(CMD_MESSAGE, '1, '0, KIND_W'(1), PORT_W'(1));
    send_beat(CMD_MESSAGE, ID_W'(1), HOP_W'(1), KIND_W'(0), PORT_W'(7));
    send_beat(CMD_MESSAGE, ID_W'(2), HOP_W'(2), KIND_W'(1), PORT_W'(8));
    send_beat(CMD_MESSAGE, ID_W'(3), HOP_W'(2), KIND_W'(2), PORT_W'(9));
    send_beat(CMD_MESSAGE, ID_W'(4), HOP_W'(2), KIND_W'(3), PORT_W'(10));
    send_beat(CMD_MESSAGE, ID_W'(5), HOP_W'(9), '1, PORT_W'(11));
    send_beat(CMD_MESSAGE, ID_W'(6), HOP_W'(9), KIND_W'(7), '0);
    send_beat(CMD_MESSAGE, 32'h8000_0000, HOP_W'(128), KIND_W'(4), PORT_W'(128));
    repeat (3) send_beat(CMD_TICK, $urandom, '1, '1, '1);
    send_beat(CMD_CLEANUP, '1, '1, '1, '1);
    send_beat(CMD_UNUSED, '1, '1, '1, '1);
    send_beat(CMD_MESSAGE, 32'h8000_0000, HOP_W'(128), KIND_W'(0), PORT_W'(1));
    // A timeout of one second: two more ticks age everything out.
    write_timeout(TMO_W'(1));
    repeat (2) send_beat(CMD_TICK, '0, '0, '0, '0);
    send_beat(CMD_CLEANUP, '0, '0, '0, '0);
    send_beat(CMD_MESSAGE, '0, HOP_W'(3), KIND_W'(0), PORT_W'(42));

    // Overfill the ring so the oldest identifiers get overwritten.
    write_timeout('1);
    for (int k = 0; k < 300; k++)
      send_beat(CMD_MESSAGE, 32'hA500_0000 + ID_W'(k), pick_hops(),
                KIND_W'($urandom_range(0, 15)), PORT_W'($urandom_range(0, 255)));
    for (int k = 0; k < 10; k++)
      send_beat(CMD_MESSAGE, 32'hA500_0000 + ID_W'(k), HOP_W'(4), KIND_W'(0), PORT_W'(k));
    for (int k = 290; k < 300; k++)
      send_beat(CMD_MESSAGE, 32'hA500_0000 + ID_W'(k), HOP_W'(4), KIND_W'(0), PORT_W'(k));
    // With no timeout at all, one tick makes the cleanup empty the full ring.
    write_timeout('0);
    send_beat(CMD_TICK, '0, '0, '0, '0);
    send_beat(CMD_CLEANUP, '0, '0, '0, '0);
    send_beat(CMD_MESSAGE, 32'hA500_0000, HOP_W'(4), KIND_W'(0), PORT_W'(5));

    timeouts[0] = '0;
    timeouts[1] = TMO_W'(1);
    timeouts[2] = TMO_W'(7);
    timeouts[3] = TIMEOUT_RESET;
    timeouts[4] = '1;
    timeouts[5] = TMO_W'($urandom_range(2, 40));
    foreach (timeouts[p]) begin
      write_timeout(timeouts[p]);
      repeat (PHASE_ITEMS) random_beat();
    end

    wait_drained();
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
hdl/fdf_pkg.sv
hdl/fdf_cell.sv
hdl/flood_duplicate_filter.sv
sim/fdf_checker.sv
sim/tb.sv
